// ===== rtl/mtr_pkg.sv =====
package mtr_pkg;

   // field and grid defaults
   localparam int FIELD_W        = 14;
   localparam int COST_W         = 8;
   localparam int OFS_W          = 6;
   localparam int CSR_IDX_W      = 3;
   localparam int DEF_GRID_COLS  = 64;
   localparam int DEF_GRID_ROWS  = 64;
   localparam int DEF_FRAC_BITS  = 8;
   localparam int JOB_FIFO_DEPTH = 4;
   localparam int LIMIT_W        = 2 * FIELD_W;

   localparam logic [COST_W-1:0] UNREACH = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GOAL_X,
      CSR_GOAL_Y,
      CSR_GOAL_RADIUS,
      CSR_HERE_X,
      CSR_HERE_Y,
      CSR_MIN_STEP
   } csr_index_type;

   typedef enum logic [1:0] {
      FOUND_NONE,
      FOUND_GOAL,
      FOUND_VANTAGE
   } found_kind_type;

   // squared distance limits, refreshed from the config registers
   typedef struct packed {
      logic [LIMIT_W-1:0] radius_sq;
      logic [LIMIT_W-1:0] min_step_sq;
   } dist_limits_type;

   typedef struct packed {
      logic [OFS_W-1:0]  cell_col;
      logic [OFS_W-1:0]  cell_row;
      logic [COST_W-1:0] east_cost;
      logic [COST_W-1:0] north_cost;
      logic              east_by_turn;
      logic              north_by_turn;
      logic              plan_done;
      logic [1:0]        found_kind;
      logic [OFS_W-1:0]  target_col;
      logic [OFS_W-1:0]  target_row;
      logic              target_east;
   } rsp_payload_type;

   // add one turn, saturating at unreachable
   function automatic logic [COST_W-1:0] turn_added(input logic [COST_W-1:0] t);
      return (t >= UNREACH - 8'd1) ? UNREACH : t + 8'd1;
   endfunction

endpackage

// ===== rtl/mtr_req_if.sv =====
interface mtr_req_if;
   logic valid;
   logic ready;
   logic drive_east_ok;
   logic drive_north_ok;
   logic quarter_turn_ok;

   modport source (output valid, output drive_east_ok, output drive_north_ok,
                   output quarter_turn_ok, input ready);
   modport sink   (input valid, input drive_east_ok, input drive_north_ok,
                   input quarter_turn_ok, output ready);
endinterface

// ===== rtl/mtr_rsp_if.sv =====
interface mtr_rsp_if import mtr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OFS_W-1:0]  cell_col;
   logic [OFS_W-1:0]  cell_row;
   logic [COST_W-1:0] east_cost;
   logic [COST_W-1:0] north_cost;
   logic              east_by_turn;
   logic              north_by_turn;
   logic              plan_done;
   logic [1:0]        found_kind;
   logic [OFS_W-1:0]  target_col;
   logic [OFS_W-1:0]  target_row;
   logic              target_east;

   modport source (output valid, output cell_col, output cell_row, output east_cost,
                   output north_cost, output east_by_turn, output north_by_turn,
                   output plan_done, output found_kind, output target_col,
                   output target_row, output target_east, input ready);
   modport sink   (input valid, input cell_col, input cell_row, input east_cost,
                   input north_cost, input east_by_turn, input north_by_turn,
                   input plan_done, input found_kind, input target_col,
                   input target_row, input target_east, output ready);
endinterface

// ===== rtl/mtr_front.sv =====
module mtr_front import mtr_pkg::*; #(
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int GRID_ROWS = DEF_GRID_ROWS,
   parameter int FRAC_BITS = DEF_FRAC_BITS,
   parameter type job_type = logic
) (
   input  logic                 clock,
   input  logic                 reset,
   mtr_req_if.sink              req_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata,
   input  logic                 q_full,
   output logic                 push,
   output job_type              push_job,
   output dist_limits_type      limits
);

   localparam int COL_W = $clog2(GRID_COLS);
   localparam int ROW_W = $clog2(GRID_ROWS);
   localparam int CXW   = COL_W + FRAC_BITS;
   localparam int CYW   = ROW_W + FRAC_BITS;
   localparam int CMAX  = (CXW > CYW) ? CXW : CYW;
   localparam int D_W   = (CMAX > FIELD_W) ? CMAX : FIELD_W;
   localparam int MAXW  = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int EW    = ((MAXW > FIELD_W) ? MAXW : FIELD_W) + 2;
   localparam int PAD_W = FIELD_W + 1;

   logic [FIELD_W-1:0] goal_x_ff, goal_y_ff, goal_radius_ff;
   logic [FIELD_W-1:0] here_x_ff, here_y_ff, min_step_ff;
   dist_limits_type    limits_ff;

   logic [COL_W-1:0] col_ff, col_in, start_cx_ff, box_w_ff;
   logic [ROW_W-1:0] row_ff, row_in, start_cy_ff, box_h_ff;

   logic [FIELD_W-1:0] gx_raw, gy_raw, hx_raw, hy_raw;
   logic [PAD_W-1:0]   pad_sum, pad;
   logic [COL_W-1:0]   gcx, new_sx, edge_x, new_bw, sx, bw, cx;
   logic [ROW_W-1:0]   gcy, new_sy, edge_y, new_bh, sy, bh, cy;
   logic [EW-1:0]      ex_sum, ey_sum;
   logic               first, empty, last;
   logic [CXW-1:0]     px;
   logic [CYW-1:0]     py;
   logic [D_W-1:0]     gxw, gyw, hxw, hyw, pxw, pyw;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff      <= '0;
         goal_y_ff      <= '0;
         goal_radius_ff <= '0;
         here_x_ff      <= '0;
         here_y_ff      <= '0;
         min_step_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GOAL_X:      goal_x_ff      <= csr_wdata;
            CSR_GOAL_Y:      goal_y_ff      <= csr_wdata;
            CSR_GOAL_RADIUS: goal_radius_ff <= csr_wdata;
            CSR_HERE_X:      here_x_ff      <= csr_wdata;
            CSR_HERE_Y:      here_y_ff      <= csr_wdata;
            CSR_MIN_STEP:    min_step_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // square the distance limits once per cycle
   always_ff @(posedge clock) begin
      limits_ff.radius_sq   <= LIMIT_W'(goal_radius_ff) * LIMIT_W'(goal_radius_ff);
      limits_ff.min_step_sq <= LIMIT_W'(min_step_ff) * LIMIT_W'(min_step_ff);
   end
   assign limits = limits_ff;

   // cell geometry
   always_comb begin
      gx_raw = goal_x_ff >> FRAC_BITS;
      gy_raw = goal_y_ff >> FRAC_BITS;
      hx_raw = here_x_ff >> FRAC_BITS;
      hy_raw = here_y_ff >> FRAC_BITS;
      gcx    = (gx_raw > FIELD_W'(GRID_COLS - 1)) ? COL_W'(GRID_COLS - 1) : COL_W'(gx_raw);
      gcy    = (gy_raw > FIELD_W'(GRID_ROWS - 1)) ? ROW_W'(GRID_ROWS - 1) : ROW_W'(gy_raw);
      new_sx = (hx_raw > FIELD_W'(GRID_COLS - 1)) ? COL_W'(GRID_COLS - 1) : COL_W'(hx_raw);
      new_sy = (hy_raw > FIELD_W'(GRID_ROWS - 1)) ? ROW_W'(GRID_ROWS - 1) : ROW_W'(hy_raw);

      // far edge of the goal zone, rounded up and clamped to the grid
      pad_sum = PAD_W'(goal_radius_ff) + PAD_W'((1 << FRAC_BITS) - 1);
      pad     = pad_sum >> FRAC_BITS;
      ex_sum  = EW'(gcx) + EW'(pad);
      ey_sum  = EW'(gcy) + EW'(pad);
      edge_x  = (ex_sum > EW'(GRID_COLS - 1)) ? COL_W'(GRID_COLS - 1) : COL_W'(ex_sum);
      edge_y  = (ey_sum > EW'(GRID_ROWS - 1)) ? ROW_W'(GRID_ROWS - 1) : ROW_W'(ey_sum);
      new_bw  = edge_x - new_sx;
      new_bh  = edge_y - new_sy;

      first = (col_ff == '0) && (row_ff == '0);
      empty = first && ((edge_x < new_sx) || (edge_y < new_sy));
      sx    = first ? new_sx : start_cx_ff;
      sy    = first ? new_sy : start_cy_ff;
      bw    = first ? new_bw : box_w_ff;
      bh    = first ? new_bh : box_h_ff;
      last  = empty || ((col_ff >= bw) && (row_ff >= bh));

      cx  = sx + col_ff;
      cy  = sy + row_ff;
      px  = {cx, 1'b1, {(FRAC_BITS - 1){1'b0}}};
      py  = {cy, 1'b1, {(FRAC_BITS - 1){1'b0}}};
      gxw = D_W'(goal_x_ff);
      gyw = D_W'(goal_y_ff);
      hxw = D_W'(here_x_ff);
      hyw = D_W'(here_y_ff);
      pxw = D_W'(px);
      pyw = D_W'(py);
   end

   // classify the transaction for the back end
   always_comb begin
      push_job.empty   = empty;
      push_job.first   = first;
      push_job.last    = last;
      push_job.in_rect = (cx <= gcx) && (cy <= gcy);
      push_job.e_ok    = req_chan.drive_east_ok;
      push_job.n_ok    = req_chan.drive_north_ok;
      push_job.q_ok    = req_chan.quarter_turn_ok;
      push_job.col     = col_ff;
      push_job.row     = row_ff;
      push_job.dxg     = (gxw > pxw) ? gxw - pxw : pxw - gxw;
      push_job.dyg     = (gyw > pyw) ? gyw - pyw : pyw - gyw;
      push_job.dxh     = (hxw > pxw) ? hxw - pxw : pxw - hxw;
      push_job.dyh     = (hyw > pyw) ? hyw - pyw : pyw - hyw;
   end

   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;

   // advance the scan: rows upward, then the next column
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (!empty) begin
         if (row_ff >= bh) begin
            row_in = '0;
            col_in = (col_ff >= bw) ? '0 : col_ff + 1'b1;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         start_cx_ff <= '0;
         start_cy_ff <= '0;
         box_w_ff    <= '0;
         box_h_ff    <= '0;
      end else if (push) begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (first) begin
            start_cx_ff <= new_sx;
            start_cy_ff <= new_sy;
            box_w_ff    <= new_bw;
            box_h_ff    <= new_bh;
         end
      end
   end

endmodule

// ===== rtl/mtr_job_fifo.sv =====
module mtr_job_fifo import mtr_pkg::*; #(
   parameter type job_type = logic,
   parameter int  DEPTH    = JOB_FIFO_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    not_empty
);

   localparam int PTR_W = $clog2(DEPTH);

   job_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign full      = (count_ff == (PTR_W + 1)'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job   = slots_ff[rd_ptr_ff];

   // store the transaction
   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_job;
   end

   // move pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

// ===== rtl/mtr_back.sv =====
module mtr_back import mtr_pkg::*; #(
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int GRID_ROWS = DEF_GRID_ROWS,
   parameter int FRAC_BITS = DEF_FRAC_BITS,
   parameter type job_type = logic
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_not_empty,
   input  job_type         head_job,
   output logic            pop,
   input  dist_limits_type limits,
   mtr_rsp_if.source       rsp_chan
);

   localparam int COL_W   = $clog2(GRID_COLS);
   localparam int ROW_W   = $clog2(GRID_ROWS);
   localparam int CXW     = COL_W + FRAC_BITS;
   localparam int CYW     = ROW_W + FRAC_BITS;
   localparam int CMAX    = (CXW > CYW) ? CXW : CYW;
   localparam int D_W     = (CMAX > FIELD_W) ? CMAX : FIELD_W;
   localparam int DIST_W  = 2 * D_W + 1;
   localparam int ENTRY_W = 2 * COST_W + 1;

   typedef struct packed {
      job_type           job;
      logic [DIST_W-1:0] dgoal;
      logic [DIST_W-1:0] dhere;
   } stage_type;

   typedef struct packed {
      logic              valid;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic              east;
      logic [COST_W-1:0] turns;
      logic [DIST_W-1:0] dist2;
   } pick_type;

   // column store: east cost, north cost, turn bit of the previous column
   logic [ENTRY_W-1:0] col_mem [GRID_ROWS];
   logic [ENTRY_W-1:0] rd_ff;
   logic               fwd_ff, fwd_in;

   logic              s0_valid_ff, out_valid_ff;
   stage_type         s0_ff, stage_in;
   logic [COST_W-1:0] below_east_ff, below_north_ff;
   logic              below_turn_ff;
   pick_type          goal_ff, vant_ff, goal_in, vant_in, base_goal, base_vant, cand;
   rsp_payload_type   out_ff, out_in;

   logic              out_adv, s0_fire, s0_take;
   logic [COST_W-1:0] col_e, col_n, east, north, straight, turning, turns;
   logic              col_t, east_turn, north_turn, reach, in_zone, far_enough;

   // handshake of the two back stages
   assign out_adv = !out_valid_ff || rsp_chan.ready;
   assign s0_fire = s0_valid_ff && out_adv;
   assign s0_take = !s0_valid_ff || out_adv;
   assign pop     = q_not_empty && s0_take;

   // squared distances for the popped cell
   always_comb begin
      stage_in.job   = head_job;
      stage_in.dgoal = DIST_W'(head_job.dxg) * DIST_W'(head_job.dxg)
                     + DIST_W'(head_job.dyg) * DIST_W'(head_job.dyg);
      stage_in.dhere = DIST_W'(head_job.dxh) * DIST_W'(head_job.dxh)
                     + DIST_W'(head_job.dyh) * DIST_W'(head_job.dyh);
      // a same-row write lands at this edge: take it from the below registers
      fwd_in = s0_fire && !s0_ff.job.empty && (s0_ff.job.row == head_job.row);
   end

   // turn cost recurrence and target selection
   always_comb begin
      col_e      = fwd_ff ? below_east_ff  : rd_ff[ENTRY_W-1 -: COST_W];
      col_n      = fwd_ff ? below_north_ff : rd_ff[COST_W:1];
      col_t      = fwd_ff ? below_turn_ff  : rd_ff[0];
      east       = UNREACH;
      north      = UNREACH;
      east_turn  = 1'b0;
      north_turn = 1'b0;
      straight   = UNREACH;
      turning    = UNREACH;

      if (s0_ff.job.empty) begin
         east = UNREACH;
      end else if (s0_ff.job.first) begin
         if (s0_ff.job.q_ok) begin
            east  = '0;
            north = '0;
         end
      end else begin
         if ((s0_ff.job.col != '0) && s0_ff.job.e_ok) begin
            straight  = col_e;
            turning   = col_t ? turn_added(col_n) : UNREACH;
            east_turn = turning < straight;
            east      = east_turn ? turning : straight;
         end
         if ((s0_ff.job.row != '0) && s0_ff.job.n_ok) begin
            north_turn = below_turn_ff && (turn_added(below_east_ff) < below_north_ff);
            north      = north_turn ? turn_added(below_east_ff) : below_north_ff;
         end
      end

      turns      = (east <= north) ? east : north;
      reach      = (turns != UNREACH);
      in_zone    = s0_ff.dgoal <= DIST_W'(limits.radius_sq);
      far_enough = s0_ff.dhere >= DIST_W'(limits.min_step_sq);

      base_goal = s0_ff.job.first ? '0 : goal_ff;
      base_vant = s0_ff.job.first ? '0 : vant_ff;

      cand.valid = 1'b1;
      cand.col   = s0_ff.job.col;
      cand.row   = s0_ff.job.row;
      cand.east  = (east <= north);
      cand.turns = turns;
      cand.dist2 = s0_ff.dgoal;

      goal_in = base_goal;
      vant_in = base_vant;
      if (reach && in_zone) begin
         if (!base_goal.valid || (turns < base_goal.turns)) goal_in = cand;
      end else if (reach && s0_ff.job.in_rect && s0_ff.job.q_ok && far_enough) begin
         if (!base_vant.valid || (s0_ff.dgoal < base_vant.dist2) ||
             ((s0_ff.dgoal == base_vant.dist2) && (turns < base_vant.turns))) begin
            vant_in = cand;
         end
      end

      out_in               = '0;
      out_in.cell_col      = OFS_W'(s0_ff.job.col);
      out_in.cell_row      = OFS_W'(s0_ff.job.row);
      out_in.east_cost     = east;
      out_in.north_cost    = north;
      out_in.east_by_turn  = east_turn;
      out_in.north_by_turn = north_turn;
      out_in.plan_done     = s0_ff.job.last;
      out_in.found_kind    = FOUND_NONE;
      if (s0_ff.job.last) begin
         if (goal_in.valid) begin
            out_in.found_kind  = FOUND_GOAL;
            out_in.target_col  = OFS_W'(goal_in.col);
            out_in.target_row  = OFS_W'(goal_in.row);
            out_in.target_east = goal_in.east;
         end else if (vant_in.valid) begin
            out_in.found_kind  = FOUND_VANTAGE;
            out_in.target_col  = OFS_W'(vant_in.col);
            out_in.target_row  = OFS_W'(vant_in.row);
            out_in.target_east = vant_in.east;
         end
      end
   end

   // column store write and registered read
   always_ff @(posedge clock) begin
      if (s0_fire && !s0_ff.job.empty) begin
         col_mem[s0_ff.job.row] <= {east, north, s0_ff.job.q_ok};
      end
   end

   always_ff @(posedge clock) begin
      if (pop) rd_ff <= col_mem[head_job.row];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         fwd_ff         <= 1'b0;
         goal_ff        <= '0;
         vant_ff        <= '0;
         below_east_ff  <= UNREACH;
         below_north_ff <= UNREACH;
         below_turn_ff  <= 1'b0;
      end else begin
         if (s0_take) s0_valid_ff <= q_not_empty;
         if (out_adv) out_valid_ff <= s0_valid_ff;
         if (pop) fwd_ff <= fwd_in;
         if (s0_fire) begin
            goal_ff <= goal_in;
            vant_ff <= vant_in;
            if (!s0_ff.job.empty) begin
               below_east_ff  <= east;
               below_north_ff <= north;
               below_turn_ff  <= s0_ff.job.q_ok;
            end
         end
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (pop) s0_ff <= stage_in;
      if (s0_fire) out_ff <= out_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.cell_col      = out_ff.cell_col;
   assign rsp_chan.cell_row      = out_ff.cell_row;
   assign rsp_chan.east_cost     = out_ff.east_cost;
   assign rsp_chan.north_cost    = out_ff.north_cost;
   assign rsp_chan.east_by_turn  = out_ff.east_by_turn;
   assign rsp_chan.north_by_turn = out_ff.north_by_turn;
   assign rsp_chan.plan_done     = out_ff.plan_done;
   assign rsp_chan.found_kind    = out_ff.found_kind;
   assign rsp_chan.target_col    = out_ff.target_col;
   assign rsp_chan.target_row    = out_ff.target_row;
   assign rsp_chan.target_east   = out_ff.target_east;

endmodule

// ===== rtl/min_turn_monotone_route_dp.sv =====
// Path: an accepted cell passes the job queue, the column store read, and the turn cost
// and target update before its result shows.
// Throughput: one cell per cycle while the result side is ready, set by the cost recurrence
// through the below-cell registers and the registered column store read.
// Reset: synchronous, clears scan indices, held targets, queue and config;
// the column store is not cleared and is always written before a value read from it is used.
module min_turn_monotone_route_dp import mtr_pkg::*; #(
   parameter int GRID_COLS = DEF_GRID_COLS,
   parameter int GRID_ROWS = DEF_GRID_ROWS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   mtr_req_if.sink              req_chan,
   mtr_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata
);

   localparam int COL_W = $clog2(GRID_COLS);
   localparam int ROW_W = $clog2(GRID_ROWS);
   localparam int CXW   = COL_W + FRAC_BITS;
   localparam int CYW   = ROW_W + FRAC_BITS;
   localparam int CMAX  = (CXW > CYW) ? CXW : CYW;
   localparam int D_W   = (CMAX > FIELD_W) ? CMAX : FIELD_W;

   // one classified cell between the front and back ends
   typedef struct packed {
      logic             empty;
      logic             first;
      logic             last;
      logic             in_rect;
      logic             e_ok;
      logic             n_ok;
      logic             q_ok;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [D_W-1:0]   dxg;
      logic [D_W-1:0]   dyg;
      logic [D_W-1:0]   dxh;
      logic [D_W-1:0]   dyh;
   } job_type;

   logic            push, q_full, pop, q_not_empty;
   job_type         push_job, head_job;
   dist_limits_type limits;

   mtr_front #(
      .GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS), .FRAC_BITS(FRAC_BITS),
      .job_type(job_type)
   ) u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .q_full(q_full), .push(push), .push_job(push_job), .limits(limits)
   );

   mtr_job_fifo #(
      .job_type(job_type), .DEPTH(JOB_FIFO_DEPTH)
   ) u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job), .full(q_full),
      .pop(pop), .pop_job(head_job), .not_empty(q_not_empty)
   );

   mtr_back #(
      .GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS), .FRAC_BITS(FRAC_BITS),
      .job_type(job_type)
   ) u_back (
      .clock(clock), .reset(reset), .q_not_empty(q_not_empty), .head_job(head_job),
      .pop(pop), .limits(limits), .rsp_chan(rsp_chan)
   );

   // an accepted cell sits in the queue on the next cycle
   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> q_not_empty)
      else $error("accepted transaction missing from job queue");

   // a turned arrival always has a finite cost
   a_turn_reachable: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> ((!rsp_chan.east_by_turn || (rsp_chan.east_cost != UNREACH)) &&
                          (!rsp_chan.north_by_turn || (rsp_chan.north_cost != UNREACH))))
      else $error("turn flag set on unreachable cost");

   // target fields stay zero unless a target is reported
   a_target_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (!rsp_chan.plan_done || (rsp_chan.found_kind == FOUND_NONE)))
      |-> ((rsp_chan.target_col == '0) && (rsp_chan.target_row == '0) &&
           !rsp_chan.target_east))
      else $error("target fields set without a reported target");

endmodule

// ===== sim/min_turn_monotone_route_dp_tb.sv =====
module min_turn_monotone_route_dp_tb;
   import mtr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS       = DEF_GRID_COLS;
   localparam int ROWS       = DEF_GRID_ROWS;
   localparam int FB         = DEF_FRAC_BITS;
   localparam int DEPTH      = ROWS + 1;
   localparam int STALL_MAX  = 2000;
   localparam int RAND_ITEMS = 530;
   localparam int CALM_ITEMS = 100;

   typedef struct {
      bit              valid;
      int              col;
      int              row;
      bit              east;
      int              turns;
      longint unsigned dist2;
   } target_pick_type;

   // turn-cost predictor and queue of expected cell results
   class route_scoreboard;
      longint unsigned goal_x, goal_y, goal_radius, here_x, here_y, min_step;
      logic [COST_W-1:0] col_east[DEPTH];
      logic [COST_W-1:0] col_north[DEPTH];
      bit                col_turn[DEPTH];
      int                below_east, below_north;
      bit                below_turn;
      int                scan_col, scan_row;
      int                start_cx, start_cy, box_w, box_h;
      target_pick_type   goal_pick, vantage_pick;
      rsp_payload_type   pending[$];
      int                errors;

      function new();
         goal_x = 0; goal_y = 0; goal_radius = 0;
         here_x = 0; here_y = 0; min_step = 0;
         foreach (col_east[k]) begin
            col_east[k] = '0; col_north[k] = '0; col_turn[k] = 0;
         end
         below_east = UNREACH; below_north = UNREACH; below_turn = 0;
         scan_col = 0; scan_row = 0;
         start_cx = 0; start_cy = 0; box_w = 0; box_h = 0;
         goal_pick = '{default: 0};
         vantage_pick = '{default: 0};
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, longint unsigned v);
         case (idx)
            CSR_GOAL_X:      goal_x = v;
            CSR_GOAL_Y:      goal_y = v;
            CSR_GOAL_RADIUS: goal_radius = v;
            CSR_HERE_X:      here_x = v;
            CSR_HERE_Y:      here_y = v;
            CSR_MIN_STEP:    min_step = v;
            default: ;
         endcase
      endfunction

      function int cell_index(longint unsigned c, int lim);
         return ((c >> FB) > lim - 1) ? lim - 1 : int'(c >> FB);
      endfunction

      function longint unsigned centre(int c);
         return (longint'(c) << FB) + (64'd1 << (FB - 1));
      endfunction

      function longint unsigned sq_dist(longint unsigned ax, longint unsigned ay,
                                        longint unsigned bx, longint unsigned by);
         longint unsigned dx, dy;
         dx = ax > bx ? ax - bx : bx - ax;
         dy = ay > by ? ay - by : by - ay;
         return dx * dx + dy * dy;
      endfunction

      function int add_turn(int t);
         return (t >= UNREACH - 1) ? UNREACH : t + 1;
      endfunction

      // predict the result of one accepted cell transaction
      function void note_cell(bit e_ok, bit n_ok, bit q_ok);
         rsp_payload_type exp;
         int gcx, gcy, pad, i, j, east, north, turns, cx, cy, straight, turning;
         bit e_turn, n_turn, last;
         longint unsigned px, py, dgoal;
         target_pick_type cand;
         exp = '0;
         gcx = cell_index(goal_x, COLS);
         gcy = cell_index(goal_y, ROWS);
         // latch geometry on the first cell of a plan
         if (scan_col == 0 && scan_row == 0) begin
            pad = int'((goal_radius + (64'd1 << FB) - 1) >> FB);
            start_cx = cell_index(here_x, COLS);
            start_cy = cell_index(here_y, ROWS);
            box_w = ((gcx + pad > COLS - 1) ? COLS - 1 : gcx + pad) - start_cx;
            box_h = ((gcy + pad > ROWS - 1) ? ROWS - 1 : gcy + pad) - start_cy;
            goal_pick = '{default: 0};
            vantage_pick = '{default: 0};
            if (box_w < 0 || box_h < 0) begin
               box_w = 0; box_h = 0;
               exp.east_cost = UNREACH;
               exp.north_cost = UNREACH;
               exp.plan_done = 1'b1;
               exp.found_kind = FOUND_NONE;
               pending.push_back(exp);
               return;
            end
         end
         i = scan_col; j = scan_row;
         east = UNREACH; north = UNREACH; e_turn = 0; n_turn = 0;
         if (i == 0 && j == 0) begin
            if (q_ok) begin
               east = 0; north = 0;
            end
         end else begin
            if (i > 0 && e_ok) begin
               straight = col_east[j];
               turning = col_turn[j] ? add_turn(col_north[j]) : UNREACH;
               e_turn = turning < straight;
               east = e_turn ? turning : straight;
            end
            if (j > 0 && n_ok) begin
               straight = below_north;
               turning = below_turn ? add_turn(below_east) : UNREACH;
               n_turn = turning < straight;
               north = n_turn ? turning : straight;
            end
         end
         col_east[j] = east; col_north[j] = north; col_turn[j] = q_ok;
         below_east = east; below_north = north; below_turn = q_ok;

         // update goal and vantage picks
         turns = east <= north ? east : north;
         if (turns != UNREACH) begin
            cx = start_cx + i; cy = start_cy + j;
            px = centre(cx); py = centre(cy);
            dgoal = sq_dist(goal_x, goal_y, px, py);
            cand = '{valid: 1, col: i, row: j, east: east <= north,
                     turns: turns, dist2: dgoal};
            if (dgoal <= goal_radius * goal_radius) begin
               if (!goal_pick.valid || turns < goal_pick.turns) goal_pick = cand;
            end else if (cx <= gcx && cy <= gcy && q_ok &&
                         sq_dist(here_x, here_y, px, py) >= min_step * min_step) begin
               if (!vantage_pick.valid || dgoal < vantage_pick.dist2 ||
                   (dgoal == vantage_pick.dist2 && turns < vantage_pick.turns))
                  vantage_pick = cand;
            end
         end
         exp.cell_col = i[OFS_W-1:0];
         exp.cell_row = j[OFS_W-1:0];
         exp.east_cost = east[COST_W-1:0];
         exp.north_cost = north[COST_W-1:0];
         exp.east_by_turn = e_turn;
         exp.north_by_turn = n_turn;

         // advance the scan
         last = (i >= box_w && j >= box_h);
         if (j >= box_h) begin
            scan_row = 0;
            scan_col = (i >= box_w) ? 0 : i + 1;
         end else begin
            scan_row = j + 1;
         end
         if (last) begin
            exp.plan_done = 1'b1;
            if (goal_pick.valid) begin
               exp.found_kind = FOUND_GOAL;
               exp.target_col = goal_pick.col[OFS_W-1:0];
               exp.target_row = goal_pick.row[OFS_W-1:0];
               exp.target_east = goal_pick.east;
            end else if (vantage_pick.valid) begin
               exp.found_kind = FOUND_VANTAGE;
               exp.target_col = vantage_pick.col[OFS_W-1:0];
               exp.target_row = vantage_pick.row[OFS_W-1:0];
               exp.target_east = vantage_pick.east;
            end
         end
         pending.push_back(exp);
      endfunction

      function void field_cmp(string nm, int e, int a);
         if (e != a) begin
            $display("%0t: mismatch %s expected %0d actual %0d", $time, nm, e, a);
            errors++;
         end
      endfunction

      // compare one result transaction with the oldest prediction
      function void check_cell(rsp_payload_type act);
         rsp_payload_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, act);
            errors++;
            return;
         end
         exp = pending.pop_front();
         field_cmp("cell_col", exp.cell_col, act.cell_col);
         field_cmp("cell_row", exp.cell_row, act.cell_row);
         field_cmp("east_cost", exp.east_cost, act.east_cost);
         field_cmp("north_cost", exp.north_cost, act.north_cost);
         field_cmp("east_by_turn", exp.east_by_turn, act.east_by_turn);
         field_cmp("north_by_turn", exp.north_by_turn, act.north_by_turn);
         field_cmp("plan_done", exp.plan_done, act.plan_done);
         field_cmp("found_kind", exp.found_kind, act.found_kind);
         field_cmp("target_col", exp.target_col, act.target_col);
         field_cmp("target_row", exp.target_row, act.target_row);
         field_cmp("target_east", exp.target_east, act.target_east);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FIELD_W-1:0] csr_wdata;
   bit calm = 0;
   int idle_cycles = 0;
   route_scoreboard sb = new();

   mtr_req_if req_if();
   mtr_rsp_if rsp_if();

   min_turn_monotone_route_dp u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // observe accepted transactions on both channels
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_cell(req_if.drive_east_ok, req_if.drive_north_ok, req_if.quarter_turn_ok);
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_cell('{rsp_if.cell_col, rsp_if.cell_row, rsp_if.east_cost,
                         rsp_if.north_cost, rsp_if.east_by_turn, rsp_if.north_by_turn,
                         rsp_if.plan_done, rsp_if.found_kind, rsp_if.target_col,
                         rsp_if.target_row, rsp_if.target_east});
   end

   // stall the result side in random bursts
   always @(negedge clock) begin
      if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_if.ready = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      rsp_if.ready = 1'b1;
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
         $display("min_turn_monotone_route_dp_tb: errors");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [FIELD_W-1:0] v);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      sb.set_reg(idx, 64'(v));
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // drop the request, hold until every result is back, then let the pipeline settle
   task automatic wait_quiet();
      req_if.valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_config(int gx, int gy, int rad, int hx, int hy, int ms);
      wait_quiet();
      write_reg(CSR_GOAL_X, FIELD_W'(gx));
      write_reg(CSR_GOAL_Y, FIELD_W'(gy));
      write_reg(CSR_GOAL_RADIUS, FIELD_W'(rad));
      write_reg(CSR_HERE_X, FIELD_W'(hx));
      write_reg(CSR_HERE_Y, FIELD_W'(hy));
      write_reg(CSR_MIN_STEP, FIELD_W'(ms));
      repeat (2) @(negedge clock);
   endtask

   // present one cell and hold it until accepted
   task automatic send_cell(bit e_ok, bit n_ok, bit q_ok);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.drive_east_ok = e_ok;
      req_if.drive_north_ok = n_ok;
      req_if.quarter_turn_ok = q_ok;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // mostly clear cells so routes reach far into the box
   task automatic send_random_cell();
      send_cell($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                $urandom_range(0, 3) != 0);
   endtask

   task automatic random_config();
      int gx, gy, hx, hy;
      gx = $urandom_range(0, 16383);
      gy = $urandom_range(0, 16383);
      hx = gx > 1024 ? gx - $urandom_range(0, 1024) : $urandom_range(0, gx);
      hy = gy > 1024 ? gy - $urandom_range(0, 1024) : $urandom_range(0, gy);
      if ($urandom_range(0, 9) == 0) hx = $urandom_range(0, 16383);
      load_config(gx, gy, $urandom_range(0, 768), hx, hy, $urandom_range(0, 600));
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.drive_east_ok = 1'b0;
      req_if.drive_north_ok = 1'b0;
      req_if.quarter_turn_ok = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // one-cell plans at reset settings: all input combinations
      for (int k = 0; k < 8; k++) send_cell(k[0], k[1], k[2]);
      // all registers at their maximum
      load_config(16383, 16383, 16383, 16383, 16383, 16383);
      for (int k = 0; k < 4; k++) send_cell(k[0], 1'b1, k[1]);
      // goal left of and below the start: empty box
      load_config(0, 0, 0, 16383, 16383, 0);
      for (int k = 0; k < 4; k++) send_cell(k[0], k[1], 1'b1);
      // small clear box whose first cell is a blocked start
      load_config(900, 900, 300, 100, 100, 0);
      for (int k = 0; k < 9; k++) send_cell(1'b1, 1'b1, k != 0);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 45 == 0) random_config();
         if (n == RAND_ITEMS - CALM_ITEMS) calm = 1;
         send_random_cell();
      end
      req_if.valid = 1'b0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      if (sb.errors == 0)
         $display("min_turn_monotone_route_dp_tb: clean");
      else
         $display("min_turn_monotone_route_dp_tb: errors");
      $finish;
   end
endmodule
